@@ hw/rtl/cstok_pkg.sv @@
// Shared types, widths and the punctuator prefix table of the source token scanner.
// Used by cstok_scan, cstok_outq and c_source_token_scanner_unit.
package cstok_pkg;

    localparam int POS_W     = 21;
    localparam int KIND_W    = 3;
    localparam int NODE_W    = 6;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int IDATA_W   = 8;
    localparam int ODATA_W   = 72;
    localparam int OFIELDS_W = 3 * POS_W + KIND_W;

    localparam logic [NODE_W-1:0] ROOT_NODE  = 6'd0;
    localparam logic [NODE_W-1:0] SLASH_NODE = 6'd18;

    typedef struct packed {
        logic [POS_W-1:0]  comments;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  tok_end;
        logic [POS_W-1:0]  tok_start;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_emit;

    function automatic logic [NODE_W-1:0] trie_next(input logic [NODE_W-1:0] node,
                                                    input logic [7:0] ch);
        logic [NODE_W-1:0] m;
        m = ROOT_NODE;
        case ({node, ch})
            {6'd0,  8'h7B}: m = 6'd1;
            {6'd0,  8'h7D}: m = 6'd2;
            {6'd0,  8'h5B}: m = 6'd3;
            {6'd0,  8'h5D}: m = 6'd4;
            {6'd0,  8'h23}: m = 6'd5;
            {6'd0,  8'h28}: m = 6'd6;
            {6'd0,  8'h29}: m = 6'd7;
            {6'd0,  8'h3C}: m = 6'd8;
            {6'd0,  8'h3A}: m = 6'd9;
            {6'd0,  8'h3E}: m = 6'd10;
            {6'd0,  8'h25}: m = 6'd11;
            {6'd0,  8'h3B}: m = 6'd12;
            {6'd0,  8'h2E}: m = 6'd13;
            {6'd0,  8'h3F}: m = 6'd14;
            {6'd0,  8'h2B}: m = 6'd15;
            {6'd0,  8'h2D}: m = 6'd16;
            {6'd0,  8'h2A}: m = 6'd17;
            {6'd0,  8'h2F}: m = 6'd18;
            {6'd0,  8'h5E}: m = 6'd19;
            {6'd0,  8'h26}: m = 6'd20;
            {6'd0,  8'h7C}: m = 6'd21;
            {6'd0,  8'h7E}: m = 6'd22;
            {6'd0,  8'h21}: m = 6'd23;
            {6'd0,  8'h3D}: m = 6'd24;
            {6'd0,  8'h2C}: m = 6'd25;
            {6'd5,  8'h23}: m = 6'd26;
            {6'd8,  8'h3A}: m = 6'd27;
            {6'd9,  8'h3E}: m = 6'd28;
            {6'd8,  8'h25}: m = 6'd29;
            {6'd11, 8'h3E}: m = 6'd30;
            {6'd11, 8'h3A}: m = 6'd31;
            {6'd13, 8'h2E}: m = 6'd32;
            {6'd9,  8'h3A}: m = 6'd33;
            {6'd13, 8'h2A}: m = 6'd34;
            {6'd15, 8'h3D}: m = 6'd35;
            {6'd16, 8'h3D}: m = 6'd36;
            {6'd17, 8'h3D}: m = 6'd37;
            {6'd18, 8'h3D}: m = 6'd38;
            {6'd11, 8'h3D}: m = 6'd39;
            {6'd19, 8'h3D}: m = 6'd40;
            {6'd20, 8'h3D}: m = 6'd41;
            {6'd21, 8'h3D}: m = 6'd42;
            {6'd8,  8'h3C}: m = 6'd43;
            {6'd10, 8'h3E}: m = 6'd44;
            {6'd24, 8'h3D}: m = 6'd45;
            {6'd23, 8'h3D}: m = 6'd46;
            {6'd8,  8'h3D}: m = 6'd47;
            {6'd10, 8'h3D}: m = 6'd48;
            {6'd20, 8'h26}: m = 6'd49;
            {6'd21, 8'h7C}: m = 6'd50;
            {6'd15, 8'h2B}: m = 6'd51;
            {6'd16, 8'h2D}: m = 6'd52;
            {6'd16, 8'h3E}: m = 6'd53;
            {6'd31, 8'h25}: m = 6'd54;
            {6'd32, 8'h2E}: m = 6'd55;
            {6'd44, 8'h3D}: m = 6'd56;
            {6'd43, 8'h3D}: m = 6'd57;
            {6'd53, 8'h2A}: m = 6'd58;
            {6'd54, 8'h3A}: m = 6'd59;
            default:        m = ROOT_NODE;
        endcase
        return m;
    endfunction

endpackage

@@ hw/rtl/cstok_scan.sv @@
// Scanner state and per-byte token logic: mode, operator prefix, offsets, comment count.
// Depends on cstok_pkg for the result types and the punctuator prefix table.
module cstok_scan #(
    parameter int unsigned MAX_SOURCE_LENGTH = 1048576
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic            i_eof,
    output cstok_pkg::t_emit o_emit
);
    import cstok_pkg::*;

    localparam logic [POS_W-1:0] POS_CAP = (MAX_SOURCE_LENGTH < 32'h1FFFFF) ?
        POS_W'(MAX_SOURCE_LENGTH) : {POS_W{1'b1}};

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_SLASH      = 4'd1;
    localparam logic [3:0] M_LINE       = 4'd2;
    localparam logic [3:0] M_BLOCK      = 4'd3;
    localparam logic [3:0] M_IDENT      = 4'd4;
    localparam logic [3:0] M_NUMBER     = 4'd5;
    localparam logic [3:0] M_CHAR_FIRST = 4'd6;
    localparam logic [3:0] M_CHAR_BODY  = 4'd7;
    localparam logic [3:0] M_STRING     = 4'd8;
    localparam logic [3:0] M_OPER       = 4'd9;

    localparam logic [KIND_W-1:0] K_IDENT  = 3'd0;
    localparam logic [KIND_W-1:0] K_NUMBER = 3'd1;
    localparam logic [KIND_W-1:0] K_CHAR   = 3'd2;
    localparam logic [KIND_W-1:0] K_STRING = 3'd3;
    localparam logic [KIND_W-1:0] K_OPER   = 3'd4;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    logic [3:0]        r_mode, n_mode;
    logic [NODE_W-1:0] r_node, n_node;
    logic [7:0]        r_prev, n_prev;
    logic [POS_W-1:0]  r_start, n_start;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_ccount, n_ccount;

    logic [POS_W-1:0]  pos_next;
    logic              is_sp, is_dig, is_let;
    logic [NODE_W-1:0] m_cur, m_slash, m_root;
    logic              to_idle;
    logic              a_v, b_v, c_v;
    t_result           a_r, b_r, c_r;
    logic [3:0]        mode_mid;
    logic [NODE_W-1:0] node_mid;

    assign pos_next = (r_pos >= POS_CAP) ? POS_CAP : r_pos + POS_W'(1);
    assign is_sp    = (i_byte == 8'h20) || (i_byte >= 8'h09 && i_byte <= 8'h0D);
    assign is_dig   = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_let   = (i_byte >= 8'h61 && i_byte <= 8'h7A) || (i_byte >= 8'h41 && i_byte <= 8'h5A);
    assign m_cur    = trie_next(r_node, i_byte);
    assign m_slash  = trie_next(SLASH_NODE, i_byte);
    assign m_root   = trie_next(ROOT_NODE, i_byte);

    always_comb begin
        mode_mid = r_mode;
        node_mid = r_node;
        n_ccount = r_ccount;
        to_idle  = 1'b0;
        a_v      = 1'b0;
        a_r      = '{comments: r_ccount, kind: K_OPER, tok_end: r_pos,
                     tok_start: r_start, last: 1'b0};
        unique case (r_mode)
            M_SLASH: begin
                if (i_byte == CH_SLASH || i_byte == CH_STAR) begin
                    mode_mid = (i_byte == CH_SLASH) ? M_LINE : M_BLOCK;
                    if (r_ccount < POS_CAP) begin
                        n_ccount = r_ccount + POS_W'(1);
                    end
                end else if (m_slash != ROOT_NODE) begin
                    mode_mid = M_OPER;
                    node_mid = m_slash;
                end else begin
                    a_v      = 1'b1;
                    mode_mid = M_IDLE;
                    node_mid = ROOT_NODE;
                    to_idle  = 1'b1;
                end
            end
            M_LINE: begin
                if (i_byte == CH_NL && r_prev != CH_BSLASH) begin
                    mode_mid = M_IDLE;
                end
            end
            M_BLOCK: begin
                if (r_prev == CH_STAR && i_byte == CH_SLASH) begin
                    mode_mid = M_IDLE;
                end
            end
            M_IDENT: begin
                if (!(is_let || is_dig || i_byte == CH_UNDER)) begin
                    a_v      = 1'b1;
                    a_r.kind = K_IDENT;
                    mode_mid = M_IDLE;
                    to_idle  = 1'b1;
                end
            end
            M_NUMBER: begin
                if (!(is_let || is_dig || i_byte == CH_DOT)) begin
                    a_v      = 1'b1;
                    a_r.kind = K_NUMBER;
                    mode_mid = M_IDLE;
                    to_idle  = 1'b1;
                end
            end
            M_CHAR_FIRST: begin
                mode_mid = M_CHAR_BODY;
            end
            M_CHAR_BODY: begin
                if (i_byte == CH_SQUOTE && r_prev != CH_BSLASH) begin
                    a_v         = 1'b1;
                    a_r.kind    = K_CHAR;
                    a_r.tok_end = pos_next;
                    mode_mid    = M_IDLE;
                end
            end
            M_STRING: begin
                if (i_byte == CH_DQUOTE && r_prev != CH_BSLASH) begin
                    a_v         = 1'b1;
                    a_r.kind    = K_STRING;
                    a_r.tok_end = pos_next;
                    mode_mid    = M_IDLE;
                end
            end
            M_OPER: begin
                if (m_cur != ROOT_NODE) begin
                    node_mid = m_cur;
                end else begin
                    a_v      = 1'b1;
                    mode_mid = M_IDLE;
                    node_mid = ROOT_NODE;
                    to_idle  = 1'b1;
                end
            end
            default: begin
                mode_mid = M_IDLE;
                to_idle  = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_mode  = mode_mid;
        n_node  = node_mid;
        n_start = r_start;
        b_v     = 1'b0;
        b_r     = '{comments: r_ccount, kind: K_OPER, tok_end: pos_next,
                    tok_start: r_pos, last: 1'b0};
        if (to_idle && !is_sp) begin
            n_start = r_pos;
            priority if (i_byte == CH_SLASH) begin
                if (i_eof) begin
                    b_v = 1'b1;
                end else begin
                    n_mode = M_SLASH;
                end
            end else if (is_let || i_byte == CH_UNDER) begin
                n_mode = M_IDENT;
            end else if (is_dig) begin
                n_mode = M_NUMBER;
            end else if (i_byte == CH_SQUOTE) begin
                n_mode = M_CHAR_FIRST;
            end else if (i_byte == CH_DQUOTE) begin
                n_mode = M_STRING;
            end else if (m_root != ROOT_NODE) begin
                n_mode = M_OPER;
                n_node = m_root;
            end else begin
                b_v = 1'b1;
            end
        end
    end

    always_comb begin
        c_v = 1'b0;
        c_r = '{comments: r_ccount, kind: K_OPER, tok_end: pos_next,
                tok_start: n_start, last: 1'b0};
        if (i_eof) begin
            unique case (n_mode)
                M_IDENT: begin
                    c_v = 1'b1;
                    c_r.kind = K_IDENT;
                end
                M_NUMBER: begin
                    c_v = 1'b1;
                    c_r.kind = K_NUMBER;
                end
                M_CHAR_FIRST, M_CHAR_BODY: begin
                    c_v = 1'b1;
                    c_r.kind = K_CHAR;
                end
                M_STRING: begin
                    c_v = 1'b1;
                    c_r.kind = K_STRING;
                end
                M_SLASH, M_OPER: begin
                    c_v = 1'b1;
                end
                default: begin
                    c_v = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_emit.v0 = a_v || b_v || c_v;
        o_emit.r0 = a_v ? a_r : (b_v ? b_r : c_r);
        o_emit.v1 = a_v ? (b_v || c_v) : (b_v && c_v);
        o_emit.r1 = (a_v && b_v) ? b_r : c_r;
        o_emit.r0.last = !o_emit.v1;
        o_emit.r1.last = 1'b1;
    end

    always_comb begin
        n_prev = i_byte;
        n_pos  = pos_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_node   <= ROOT_NODE;
            r_prev   <= '0;
            r_start  <= '0;
            r_pos    <= '0;
            r_ccount <= '0;
        end else if (i_fire) begin
            if (i_eof) begin
                r_mode   <= M_IDLE;
                r_node   <= ROOT_NODE;
                r_prev   <= '0;
                r_start  <= '0;
                r_pos    <= '0;
                r_ccount <= '0;
            end else begin
                r_mode   <= n_mode;
                r_node   <= n_node;
                r_prev   <= n_prev;
                r_start  <= n_start;
                r_pos    <= n_pos;
                r_ccount <= n_ccount;
            end
        end
    end

endmodule

@@ hw/rtl/cstok_outq.sv @@
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on cstok_pkg for t_result and t_emit.
module cstok_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cstok_pkg::t_emit  i_emit,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output cstok_pkg::t_result o_res
);
    import cstok_pkg::*;

    t_result             r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                push0, push1, pop;

    assign push0   = i_push && i_emit.v0;
    assign push1   = i_push && i_emit.v1;
    assign pop     = i_pop && o_valid;
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_res   = r_q[r_rd];

    always_comb begin
        n_wr  = r_wr + QPTR_W'(push0) + QPTR_W'(push1);
        n_rd  = r_rd + QPTR_W'(pop);
        n_cnt = r_cnt + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_q[r_wr] <= i_emit.r0;
        end
        if (push1) begin
            r_q[r_wr + QPTR_W'(1)] <= i_emit.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/c_source_token_scanner_unit.sv @@
// Top level of the C/C++ source token scanner: input register, scanner, result queue.
// Depends on cstok_pkg, cstok_scan and cstok_outq.
//
// Usage:
//   Slave stream s_*: one source byte per word in s_tdata, s_tlast marks the
//   final byte of a source. After that byte all offsets and the comment count
//   restart at zero for the next source.
//   Master stream m_*: one token per word, 0 to 2 words per byte; m_tlast
//   marks the last token caused by a byte.
//   Path: input register, then result queue, then m_*.
//   Throughput: one byte per cycle while the queue has room; the four-entry
//   result queue absorbs the second token of a byte that yields two.
//   The input register is processed only while the queue has room for two
//   results, so a stalled m_tready backs up into s_tready after the queue
//   fills; s_tready never depends combinationally on m_tready.
//   Reset (i_rst_n low, synchronous) empties the queue and the input
//   register and returns the scanner to offset 0, idle between tokens.
module c_source_token_scanner_unit #(
    parameter int unsigned MAX_SOURCE_LENGTH = 1048576
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cstok_pkg::IDATA_W-1:0]     s_tdata,  // [7:0] source_byte
    input  logic                              s_tlast,  // end_of_source
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [20:0] token_start, [41:21] token_end, [44:42] token_kind,
    // [65:45] comments_so_far, [71:66] zero
    output logic [cstok_pkg::ODATA_W-1:0]     m_tdata,
    output logic                              m_tlast   // last_of_run
);
    import cstok_pkg::*;

    logic        r_in_v;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;
    logic        fire, room;
    t_emit       emit;
    t_result     head;

    assign fire     = r_in_v && room;
    assign s_tready = !r_in_v || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
            r_in_eof  <= s_tlast;
        end
    end

    cstok_scan #(
        .MAX_SOURCE_LENGTH(MAX_SOURCE_LENGTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .o_emit  (emit)
    );

    cstok_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_emit  (emit),
        .i_pop   (m_tready),
        .o_room  (room),
        .o_valid (m_tvalid),
        .o_res   (head)
    );

    assign m_tdata = {(ODATA_W - OFIELDS_W)'(0), head.comments, head.kind,
                      head.tok_end, head.tok_start};
    assign m_tlast = head.last;

endmodule

@@ hw/rtl/cstok_check.sv @@
// Port-level assertions for c_source_token_scanner_unit, attached by bind.
// Depends on cstok_pkg for the stream widths.
module cstok_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [cstok_pkg::IDATA_W-1:0] s_tdata,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cstok_pkg::ODATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import cstok_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled token word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("reset did not clear the word path");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[44:42] <= 3'd4)
        else $error("token kind out of range");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[20:0] <= m_tdata[41:21])
        else $error("token ends before it starts");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[71:66] == 6'd0)
        else $error("token word padding not zero");

endmodule

bind c_source_token_scanner_unit cstok_check u_cstok_check (.*);
